>>> design/chimp_float_xor_encoder_top_defines.svh
// Assertion macros used by the encoder checker.
`ifndef CHIMP_FLOAT_XOR_ENCODER_TOP_DEFINES_SVH
`define CHIMP_FLOAT_XOR_ENCODER_TOP_DEFINES_SVH

// Antecedent in one cycle implies consequent in the next, ignored while in reset.
`define CHIMP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("chimp encoder check failed");

// Consequent holds in the cycle after reset is sampled low.
`define CHIMP_ASSERT_AFTER_RESET(lbl, cons) \
    lbl: assert property (@(posedge i_clk) (!i_rst_n) |=> (cons)) \
        else $error("chimp encoder reset check failed");

`endif

>>> design/chimp_enc_pkg.sv
// Types, constants and helper functions of the Chimp XOR encoder.
package chimp_enc_pkg;

    localparam int RING_DEPTH_DEF = 128;
    localparam int KEY_BITS_DEF   = 14;
    localparam int COUNT_BITS_DEF = 32;
    localparam int EPOCH_BITS     = 8;
    localparam int VALUE_W        = 64;

    localparam logic [1:0] PFX_EXACT     = 2'b00;
    localparam logic [1:0] PFX_TRAIL     = 2'b01;
    localparam logic [1:0] PFX_SAME_LEAD = 2'b10;
    localparam logic [1:0] PFX_NEW_LEAD  = 2'b11;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               first_of_block;
    } t_in;

    typedef struct packed {
        logic               raw_value;
        logic [1:0]         prefix;
        logic [6:0]         ref_index;
        logic [2:0]         lead_code;
        logic [5:0]         sig_len;
        logic [VALUE_W-1:0] payload;
        logic [6:0]         payload_len;
    } t_out;

    typedef struct packed {
        logic look;
        logic new_block;
    } t_hash_cmd;

    function automatic int floor_log2(int v);
        int r;
        r = 0;
        for (int i = 0; i < 30; i++) begin
            if ((2 << i) <= v) begin
                r = i + 1;
            end
        end
        return r;
    endfunction

    // trailing zeros of a 64-bit word, 64 for zero; halving search
    function automatic logic [6:0] ctz64(logic [63:0] x);
        logic [63:0] y;
        logic [6:0]  n;
        y = x;
        n = '0;
        if (x == '0) begin
            n = 7'd64;
        end else begin
            if (y[31:0] == '0) begin n = n + 7'd32; y = y >> 32; end
            if (y[15:0] == '0) begin n = n + 7'd16; y = y >> 16; end
            if (y[7:0] == '0)  begin n = n + 7'd8;  y = y >> 8;  end
            if (y[3:0] == '0)  begin n = n + 7'd4;  y = y >> 4;  end
            if (y[1:0] == '0)  begin n = n + 7'd2;  y = y >> 2;  end
            if (y[0] == 1'b0)  begin n = n + 7'd1;  end
        end
        return n;
    endfunction

    // leading zeros of a 64-bit word, 64 for zero
    function automatic logic [6:0] clz64(logic [63:0] x);
        logic [63:0] y;
        logic [6:0]  n;
        y = x;
        n = '0;
        if (x == '0) begin
            n = 7'd64;
        end else begin
            if (y[63:32] == '0) begin n = n + 7'd32; y = y << 32; end
            if (y[63:48] == '0) begin n = n + 7'd16; y = y << 16; end
            if (y[63:56] == '0) begin n = n + 7'd8;  y = y << 8;  end
            if (y[63:60] == '0) begin n = n + 7'd4;  y = y << 4;  end
            if (y[63:62] == '0) begin n = n + 7'd2;  y = y << 2;  end
            if (y[63] == 1'b0)  begin n = n + 7'd1;  end
        end
        return n;
    endfunction

    function automatic logic [2:0] lead_code_of(logic [6:0] clz);
        logic [2:0] c;
        if (clz < 7'd8)       c = 3'd0;
        else if (clz < 7'd12) c = 3'd1;
        else if (clz < 7'd16) c = 3'd2;
        else if (clz < 7'd18) c = 3'd3;
        else if (clz < 7'd20) c = 3'd4;
        else if (clz < 7'd22) c = 3'd5;
        else if (clz < 7'd24) c = 3'd6;
        else                  c = 3'd7;
        return c;
    endfunction

    function automatic logic [4:0] lead_round(logic [2:0] code);
        logic [4:0] r;
        case (code)
            3'd0:    r = 5'd0;
            3'd1:    r = 5'd8;
            3'd2:    r = 5'd12;
            3'd3:    r = 5'd16;
            3'd4:    r = 5'd18;
            3'd5:    r = 5'd20;
            3'd6:    r = 5'd22;
            3'd7:    r = 5'd24;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

>>> design/chimp_float_xor_encoder_top.sv
// Chimp XOR encoder: one value per input beat, one code word per output beat.
//
// Input channel i_in_valid / o_in_stall / i_in_data carries a value and a
// first-of-block flag. Output channel o_out_valid / i_out_stall / o_out_data
// carries the code fields. A beat moves on an edge with valid high, stall low.
// i_cfg_we / i_cfg_wdata write the width mode (1 = 64-bit, reset value); write
// it only while the block holds no beat in flight.
//
// A new beat is taken every cycle while o_in_stall is low. The hash-table
// read, then the ring read at the matched position, then the trailing/leading
// zero counts and the class step each take one pipeline stage.
// The ring and the last-position table are read-modify-write memories; the
// ring write of one beat is forwarded to the next beat's previous-value read.
// Reset and every 255th block start run a sweep over the last-position table,
// during which o_in_stall is high.
// When the receiver stalls, the result stays in the output register and the
// next one lands in a skid register; o_in_stall rises once the skid is full.
module chimp_float_xor_encoder_top #(
    parameter int RING_DEPTH = chimp_enc_pkg::RING_DEPTH_DEF,
    parameter int KEY_BITS   = chimp_enc_pkg::KEY_BITS_DEF,
    parameter int COUNT_BITS = chimp_enc_pkg::COUNT_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  chimp_enc_pkg::t_in   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output chimp_enc_pkg::t_out  o_out_data,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_wdata
);

    localparam int VW           = chimp_enc_pkg::VALUE_W;
    localparam int RIDX_W       = $clog2(RING_DEPTH);
    localparam int NARROW_DEPTH = RING_DEPTH / 2;
    localparam logic [6:0] THRESH_WIDE   = 7'(6 + chimp_enc_pkg::floor_log2(RING_DEPTH));
    localparam logic [6:0] THRESH_NARROW = 7'(6 + chimp_enc_pkg::floor_log2(NARROW_DEPTH));

    typedef struct packed {
        logic [COUNT_BITS-1:0] pos;
        logic [RIDX_W-1:0]     pos_w;
        logic [RIDX_W-1:0]     pos_n;
    } t_slot;

    // mode and block counters
    logic                  r_wide;
    logic [COUNT_BITS-1:0] r_count;
    logic [RIDX_W-1:0]     r_pos_w;
    logic [RIDX_W-1:0]     r_pos_n;

    logic en;
    logic in_acc;
    logic in_first;
    logic hash_busy;
    logic [VW-1:0]         v_in;
    logic [VW-1:0]         vmask;
    logic [KEY_BITS-1:0]   key;
    logic [RIDX_W-1:0]     cur_pos;
    logic [RIDX_W-1:0]     n_pos_w;
    logic [RIDX_W-1:0]     n_pos_n;
    logic [COUNT_BITS-1:0] n_count;
    logic [RIDX_W-1:0]     new_wpos;
    chimp_enc_pkg::t_hash_cmd hash_cmd;
    t_slot                 hash_wr;
    logic [$bits(t_slot)-1:0] hash_rd;
    t_slot                 slot_q;
    logic                  hash_hit;

    // ring memory
    logic [VW-1:0]         r_ring [RING_DEPTH];
    logic [RING_DEPTH-1:0] r_ring_vld;
    logic [VW-1:0]         r_ra_q;
    logic                  r_ra_ok;
    logic [VW-1:0]         r_rb_q;
    logic                  r_rb_ok;
    logic                  ra_fwd;
    logic                  ring_we;

    // stage 1
    logic                  r1_valid;
    logic                  r1_first;
    logic [VW-1:0]         r1_v;
    logic [COUNT_BITS-1:0] r1_count;
    logic [RIDX_W-1:0]     r1_ref;
    logic [RIDX_W-1:0]     r1_wpos;
    logic [COUNT_BITS-1:0] match;
    logic [COUNT_BITS-1:0] diff;
    logic [COUNT_BITS-1:0] depth_cur;
    logic [RIDX_W-1:0]     mpos;
    logic                  win;
    logic [VW-1:0]         x_prev;

    // stage 2
    logic                  r2_valid;
    logic                  r2_first;
    logic [VW-1:0]         r2_v;
    logic [VW-1:0]         r2_xprev;
    logic [RIDX_W-1:0]     r2_ref;
    logic                  r2_win;
    logic [RIDX_W-1:0]     r2_mpos;
    logic [VW-1:0]         t_xor;
    logic                  use_match;
    logic [6:0]            thresh;
    logic [VW-1:0]         x_sel;
    logic [RIDX_W-1:0]     ref_sel;

    // stage 3
    logic                  r3_valid;
    logic                  r3_first;
    logic [VW-1:0]         r3_x;
    logic [RIDX_W-1:0]     r3_ref;
    logic [6:0]            tz_full;
    logic [6:0]            lz_full;
    logic [6:0]            tz_cur;
    logic [6:0]            lz_cur;

    // stage 4
    logic                  r4_valid;
    logic                  r4_first;
    logic [VW-1:0]         r4_x;
    logic [RIDX_W-1:0]     r4_ref;
    logic [6:0]            r4_tz;
    logic [6:0]            r4_lz;
    logic [4:0]            r_prev_lead;
    logic                  r_prev_ok;
    logic [4:0]            n_prev_lead;
    logic                  n_prev_ok;
    chimp_enc_pkg::t_out   n_item;

    // output register and skid
    logic                  r_out_valid;
    chimp_enc_pkg::t_out   r_out;
    logic                  r_skid_valid;
    chimp_enc_pkg::t_out   r_skid;
    logic                  out_take;

    assign en         = !r_skid_valid;
    assign o_in_stall = r_skid_valid | hash_busy;
    assign in_acc     = i_in_valid & ~o_in_stall;
    assign in_first   = i_in_data.first_of_block;
    assign out_take   = r_out_valid & ~i_out_stall;

    assign vmask   = r_wide ? '1 : {{(VW-32){1'b0}}, 32'hFFFF_FFFF};
    assign v_in    = i_in_data.value & vmask;
    assign key     = r_wide ? i_in_data.value[KEY_BITS-1:0]
                            : {1'b0, i_in_data.value[KEY_BITS-2:0]};
    assign cur_pos = r_wide ? r_pos_w : r_pos_n;
    assign n_pos_w = (r_pos_w == RIDX_W'(RING_DEPTH - 1)) ? '0 : r_pos_w + 1'b1;
    assign n_pos_n = (r_pos_n == RIDX_W'(NARROW_DEPTH - 1)) ? '0 : r_pos_n + 1'b1;
    assign n_count = r_count + 1'b1;
    assign new_wpos = in_first ? '0 : (r_wide ? n_pos_w : n_pos_n);

    assign hash_cmd.look      = in_acc & ~in_first;
    assign hash_cmd.new_block = in_acc & in_first;
    assign hash_wr.pos        = n_count;
    assign hash_wr.pos_w      = n_pos_w;
    assign hash_wr.pos_n      = n_pos_n;

    chimp_enc_hash #(
        .KEY_BITS (KEY_BITS),
        .DATA_W   ($bits(t_slot))
    ) u_hash (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (hash_cmd),
        .i_key     (key),
        .i_wr_data (hash_wr),
        .o_rd_data (hash_rd),
        .o_hit     (hash_hit),
        .o_busy    (hash_busy)
    );

    assign slot_q = hash_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wide <= 1'b1;
        end else if (i_cfg_we) begin
            r_wide <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_pos_w <= '0;
            r_pos_n <= '0;
        end else if (in_acc) begin
            if (in_first) begin
                r_count <= '0;
                r_pos_w <= '0;
                r_pos_n <= '0;
            end else begin
                r_count <= n_count;
                r_pos_w <= n_pos_w;
                r_pos_n <= n_pos_n;
            end
        end
    end

    // ---------------- ring memory ----------------
    assign ring_we = en & r1_valid;
    assign ra_fwd  = r1_valid & (r1_wpos == cur_pos);

    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            r_ring[r1_wpos] <= r1_v;
        end
        if (in_acc) begin
            r_ra_q <= ra_fwd ? r1_v : r_ring[cur_pos];
        end
        if (ring_we) begin
            r_rb_q <= r_ring[mpos];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_vld <= '0;
            r_ra_ok    <= 1'b0;
            r_rb_ok    <= 1'b0;
        end else begin
            if (in_acc) begin
                r_ra_ok <= ra_fwd | r_ring_vld[cur_pos];
            end
            if (ring_we) begin
                r_rb_ok <= r_ring_vld[mpos];
            end
            // a new block wipes the ring even if an older beat writes now
            if (in_acc & in_first) begin
                r_ring_vld <= '0;
            end else if (ring_we) begin
                r_ring_vld[r1_wpos] <= 1'b1;
            end
        end
    end

    // ---------------- stage 1: window test ----------------
    assign match     = hash_hit ? slot_q.pos : '0;
    assign mpos      = hash_hit ? (r_wide ? slot_q.pos_w : slot_q.pos_n) : '0;
    assign diff      = r1_count - match;
    assign depth_cur = r_wide ? COUNT_BITS'(RING_DEPTH) : COUNT_BITS'(NARROW_DEPTH);
    assign win       = diff < depth_cur;
    assign x_prev    = r1_v ^ ((r_ra_ok ? r_ra_q : '0) & vmask);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= in_acc;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r1_first <= in_first;
            r1_v     <= v_in;
            r1_count <= r_count;
            r1_ref   <= cur_pos;
            r1_wpos  <= new_wpos;
        end
        if (en) begin
            r2_first <= r1_first;
            r2_v     <= r1_v;
            r2_xprev <= x_prev;
            r2_ref   <= r1_ref;
            r2_win   <= win;
            r2_mpos  <= mpos;
            r3_first <= r2_first;
            r3_x     <= x_sel;
            r3_ref   <= ref_sel;
            r4_first <= r3_first;
            r4_x     <= r3_x;
            r4_ref   <= r3_ref;
            r4_tz    <= tz_cur;
            r4_lz    <= lz_cur;
        end
    end

    // ---------------- stage 2: pick reference ----------------
    assign thresh    = r_wide ? THRESH_WIDE : THRESH_NARROW;
    assign t_xor     = r2_v ^ ((r_rb_ok ? r_rb_q : '0) & vmask);
    assign use_match = r2_win & (chimp_enc_pkg::ctz64(t_xor) > thresh);
    assign x_sel     = r2_first ? r2_v : (use_match ? t_xor : r2_xprev);
    assign ref_sel   = r2_first ? '0 : (use_match ? r2_mpos : r2_ref);

    // ---------------- stage 3: zero counts ----------------
    assign tz_full = chimp_enc_pkg::ctz64(r3_x);
    assign lz_full = chimp_enc_pkg::clz64(r3_x);
    // in 32-bit mode the upper half is zero, so leading count is offset by 32
    assign tz_cur  = r_wide ? tz_full : ((tz_full > 7'd32) ? 7'd32 : tz_full);
    assign lz_cur  = r_wide ? lz_full : (lz_full - 7'd32);

    // ---------------- stage 4: classify ----------------
    always_comb begin
        logic [6:0] bits;
        logic [2:0] code;
        logic [6:0] lz_r;
        logic [6:0] sig;
        bits = r_wide ? 7'd64 : 7'd32;
        code = chimp_enc_pkg::lead_code_of(r4_lz);
        lz_r = 7'(chimp_enc_pkg::lead_round(code));
        sig  = (r4_x == '0) ? 7'd0 : (bits - lz_r - r4_tz);

        n_prev_lead = r_prev_lead;
        n_prev_ok   = r_prev_ok;

        n_item.raw_value   = 1'b0;
        n_item.prefix      = chimp_enc_pkg::PFX_EXACT;
        n_item.ref_index   = 7'(r4_ref);
        n_item.lead_code   = code;
        n_item.sig_len     = 6'(sig);
        n_item.payload     = r4_x;
        n_item.payload_len = 7'd0;

        if (r4_first) begin
            n_item.raw_value   = 1'b1;
            n_item.ref_index   = '0;
            n_item.lead_code   = '0;
            n_item.sig_len     = '0;
            n_item.payload_len = bits;
            n_prev_lead        = '0;
            n_prev_ok          = 1'b1;
        end else if (r4_x == '0) begin
            n_item.payload = '0;
            n_prev_ok      = 1'b0;
        end else if (r4_tz > thresh) begin
            n_item.prefix      = chimp_enc_pkg::PFX_TRAIL;
            n_item.payload     = r4_x >> r4_tz;
            n_item.payload_len = sig;
            n_prev_ok          = 1'b0;
        end else begin
            n_item.prefix      = (r_prev_ok && (r_prev_lead == lz_r[4:0]))
                                 ? chimp_enc_pkg::PFX_SAME_LEAD
                                 : chimp_enc_pkg::PFX_NEW_LEAD;
            n_item.payload_len = bits - lz_r;
            n_prev_lead        = lz_r[4:0];
            n_prev_ok          = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_lead <= '0;
            r_prev_ok   <= 1'b1;
        end else if (en & r4_valid) begin
            r_prev_lead <= n_prev_lead;
            r_prev_ok   <= n_prev_ok;
        end
    end

    // ---------------- output register and skid ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (en) begin
            if (!r_out_valid || out_take) begin
                r_out_valid <= r4_valid;
            end else if (r4_valid) begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_skid_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (!r_out_valid || out_take) begin
                r_out <= n_item;
            end else if (r4_valid) begin
                r_skid <= n_item;
            end
        end else if (out_take) begin
            r_out <= r_skid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> design/chimp_enc_hash.sv
// Last-position table: key-addressed memory with epoch tags and a clearing sweep.
module chimp_enc_hash #(
    parameter int KEY_BITS = chimp_enc_pkg::KEY_BITS_DEF,
    parameter int DATA_W   = 48
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  chimp_enc_pkg::t_hash_cmd  i_cmd,
    input  logic [KEY_BITS-1:0]       i_key,
    input  logic [DATA_W-1:0]         i_wr_data,
    output logic [DATA_W-1:0]         o_rd_data,
    output logic                      o_hit,
    output logic                      o_busy
);

    localparam int EW    = chimp_enc_pkg::EPOCH_BITS;
    localparam int DEPTH = 1 << KEY_BITS;

    typedef struct packed {
        logic [EW-1:0]     epoch;
        logic [DATA_W-1:0] data;
    } t_slot;

    t_slot               r_mem [DEPTH];
    t_slot               r_q;
    logic [EW-1:0]       r_epoch;
    logic                r_busy;
    logic [KEY_BITS-1:0] r_sweep_addr;

    // read-first: a lookup sees the entry as it was before its own write
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_sweep_addr] <= '{epoch: '0, data: '0};
        end else if (i_cmd.look) begin
            r_mem[i_key] <= '{epoch: r_epoch, data: i_wr_data};
        end
        if (i_cmd.look) begin
            r_q <= r_mem[i_key];
        end
    end

    // epoch 0 marks swept entries, so live epochs run 1..max
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b1;
            r_sweep_addr <= '0;
            r_epoch      <= EW'(1);
        end else if (r_busy) begin
            r_sweep_addr <= r_sweep_addr + 1'b1;
            if (r_sweep_addr == '1) begin
                r_busy <= 1'b0;
            end
        end else if (i_cmd.new_block) begin
            if (r_epoch == '1) begin
                r_busy       <= 1'b1;
                r_sweep_addr <= '0;
                r_epoch      <= EW'(1);
            end else begin
                r_epoch <= r_epoch + 1'b1;
            end
        end
    end

    assign o_rd_data = r_q.data;
    assign o_hit     = (r_q.epoch == r_epoch);
    assign o_busy    = r_busy;

endmodule

>>> design/chimp_enc_chk.sv
// Port-level checker for the encoder top level, with its bind.
`include "chimp_float_xor_encoder_top_defines.svh"

module chimp_enc_chk (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input chimp_enc_pkg::t_in   i_in_data,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input chimp_enc_pkg::t_out  o_out_data,
    input logic                 i_cfg_we,
    input logic                 i_cfg_wdata
);

    // a stalled result beat stays offered and unchanged
    `CHIMP_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid)
    `CHIMP_ASSERT_NEXT(a_out_stable, o_out_valid && i_out_stall, $stable(o_out_data))

    // reset empties the pipeline and starts the table sweep
    `CHIMP_ASSERT_AFTER_RESET(a_rst_no_out, !o_out_valid)
    `CHIMP_ASSERT_AFTER_RESET(a_rst_sweep, o_in_stall)

endmodule

bind chimp_float_xor_encoder_top chimp_enc_chk u_chimp_enc_chk (.*);
